// ===== design/raw10_line_pack_unpack_macros.svh =====
// assertion macros for the raw10 line pack/unpack checker
// no dependencies; included by files that carry concurrent assertions
`ifndef RAW10_LINE_PACK_UNPACK_MACROS_SVH
`define RAW10_LINE_PACK_UNPACK_MACROS_SVH

// property checked at every rising clock edge outside reset
`define RLPU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define RLPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rlpu_pkg.sv =====
// shared types and constants for the raw10 line pack/unpack block
// no dependencies; used by all rlpu modules and the top level
`timescale 1ns / 1ps
`default_nettype none

package rlpu_pkg;

  localparam logic [1:0] MODE_COPY   = 2'd0;
  localparam logic [1:0] MODE_UNPACK = 2'd1;
  localparam logic [1:0] MODE_PACK   = 2'd2;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PIXELS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_BIT   = 4'd3;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] line_pixels;
    logic [3:0]  shift_amount;
    logic [2:0]  start_bit;
  } cfg_t;

  // one accepted item with its one or two results
  typedef struct packed {
    logic [15:0] data0;
    logic [7:0]  mask0;
    logic        last0;
    logic        two;
    logic [7:0]  data1;
    logic [7:0]  mask1;
    logic        last1;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/raw10_line_pack_unpack.sv =====
// The block takes one byte or pixel per clock while its queue is not full and gives
// one result per clock while the output is ready: copy and unpack items make at most
// one result, and a pack item that completes two bytes (or a line-end item with a
// partial tail byte) makes two, which the output serializer sends one after the other
// while the two-entry queue keeps accepting until it fills. Over a long pack line
// every fourth pixel makes two bytes, so even with the output always ready the queue
// fills and the input stalls. Results pass through the queue and output registers.
// Input items that produce no result (unpack bytes that do not finish a pixel,
// pixels past the line limit) are consumed without an output. Configuration is
// written on the cfg channel, always ready; writing the mode register restarts the
// line state.
// top level; depends on rlpu_pkg, rlpu_front, rlpu_fifo, rlpu_back
`timescale 1ns / 1ps
`default_nettype none

module raw10_line_pack_unpack #(
  parameter int unsigned MAX_LINE_PIXELS = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // cfg write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rlpu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rlpu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input stream
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [15:0]                       s_axis_tdata_i,   // [15:0] in_data
  input  wire logic                              s_axis_tlast_i,   // in_line_end
  // output stream
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [23:0]                            m_axis_tdata_o,   // [15:0] out_data, [23:16] byte_mask
  output logic                                   m_axis_tlast_o    // out_line_end
);

  rlpu_pkg::cfg_t   cfg_q;
  rlpu_pkg::entry_t push_entry, head_entry;
  logic cfg_we, mode_wr;
  logic push, pop, q_full, q_empty;
  logic [15:0] out_data;
  logic [7:0]  out_mask;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign mode_wr     = cfg_we && (cfg_index_i == rlpu_pkg::REG_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= rlpu_pkg::MODE_COPY;
      cfg_q.line_pixels  <= 13'd1;
      cfg_q.shift_amount <= 4'd0;
      cfg_q.start_bit    <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        rlpu_pkg::REG_MODE:        cfg_q.mode         <= cfg_data_i[1:0];
        rlpu_pkg::REG_LINE_PIXELS: cfg_q.line_pixels  <= cfg_data_i[12:0];
        rlpu_pkg::REG_SHIFT:       cfg_q.shift_amount <= cfg_data_i[3:0];
        rlpu_pkg::REG_START_BIT:   cfg_q.start_bit    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  rlpu_front #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .clear_i    (mode_wr),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  rlpu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_entry)
  );

  rlpu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (head_entry),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (out_data),
    .out_mask_o  (out_mask),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {out_mask, out_data};

endmodule

`default_nettype wire

// ===== design/rlpu_fifo.sv =====
// small result queue between the front and back parts
// depends on rlpu_pkg (entry_t, QUEUE_DEPTH)
`timescale 1ns / 1ps
`default_nettype none

module rlpu_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rlpu_pkg::entry_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output rlpu_pkg::entry_t      head_o
);

  localparam int unsigned PW = (rlpu_pkg::QUEUE_DEPTH > 1) ? $clog2(rlpu_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(rlpu_pkg::QUEUE_DEPTH + 1);

  rlpu_pkg::entry_t mem_q [rlpu_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign full_o  = (count_q == CW'(rlpu_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(rlpu_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(rlpu_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/rlpu_front.sv =====
// front part: accepts items, keeps the per-line bit state, forms results
// depends on rlpu_pkg (cfg_t, entry_t, mode constants)
`timescale 1ns / 1ps
`default_nettype none

module rlpu_front #(
  parameter int unsigned MAX_LINE_PIXELS = 4096
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire rlpu_pkg::cfg_t cfg_i,
  input  wire logic           clear_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [15:0]    in_data_i,
  input  wire logic           in_last_i,
  input  wire logic           q_full_i,
  output logic                push_o,
  output rlpu_pkg::entry_t    entry_o
);

  localparam int unsigned PCW  = $clog2(MAX_LINE_PIXELS + 1);
  localparam int unsigned PCW1 = PCW + 1;

  logic [15:0]    buf_q, buf_d;
  logic [4:0]     cnt_q, cnt_d;
  logic [PCW-1:0] pc_q, pc_d;
  logic           start_q, start_d;

  logic [2:0]     off;
  logic [PCW-1:0] limit;
  logic           accept, has_res;

  // unpack path
  logic [15:0] u_buf, u_buf_n;
  logic [4:0]  u_cnt, u_cnt_n;
  logic        u_emit, u_fire, u_last;
  logic [9:0]  u_pix;

  // pack path
  logic [9:0]  p_pix;
  logic [15:0] p_base_buf, p_buf, p_buf_n;
  logic [2:0]  p_base_sh;
  logic [4:0]  p_cnt, p_cnt_n;
  logic [7:0]  p_fmask, p_tmask;
  logic        p_full2;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && has_res;

  assign off   = {cfg_i.start_bit[2:1], 1'b0};
  assign limit = (32'(cfg_i.line_pixels) > 32'(MAX_LINE_PIXELS)) ?
                 PCW'(MAX_LINE_PIXELS) : PCW'(cfg_i.line_pixels);

  always_comb begin
    if (start_q) begin
      u_buf = 16'(in_data_i[7:0]) >> off;
      u_cnt = 5'd8 - 5'(off);
    end else begin
      u_buf = buf_q | (16'(in_data_i[7:0]) << cnt_q[3:0]);
      u_cnt = cnt_q + 5'd8;
    end
    u_emit  = (u_cnt >= 5'd10);
    u_fire  = u_emit && (pc_q < limit);
    u_pix   = u_buf[9:0];
    u_last  = ((PCW1'(pc_q) + 1'b1) == PCW1'(limit)) || in_last_i;
    u_buf_n = u_emit ? (u_buf >> 10) : u_buf;
    u_cnt_n = u_emit ? (u_cnt - 5'd10) : u_cnt;
  end

  always_comb begin
    p_pix      = 10'(in_data_i >> cfg_i.shift_amount);
    p_base_buf = start_q ? 16'h0000 : buf_q;
    p_base_sh  = start_q ? off : cnt_q[2:0];
    p_fmask    = start_q ? 8'(8'hff << off) : 8'hff;
    p_buf      = p_base_buf | (16'(p_pix) << p_base_sh);
    p_cnt      = 5'(p_base_sh) + 5'd10;
    // two whole bytes ready, nothing left over
    p_full2    = (p_cnt == 5'd16);
    p_buf_n    = p_full2 ? 16'h0000 : (p_buf >> 8);
    p_cnt_n    = p_full2 ? 5'd0 : (p_cnt - 5'd8);
    p_tmask    = ~(8'hff << p_cnt_n[2:0]);
  end

  always_comb begin
    entry_o = '0;
    has_res = 1'b0;
    buf_d   = buf_q;
    cnt_d   = cnt_q;
    pc_d    = pc_q;
    start_d = start_q;
    case (cfg_i.mode)
      rlpu_pkg::MODE_COPY: begin
        has_res       = 1'b1;
        entry_o.data0 = 16'(in_data_i[7:0]);
        entry_o.mask0 = 8'hff;
        entry_o.last0 = in_last_i;
      end
      rlpu_pkg::MODE_UNPACK: begin
        has_res       = u_fire;
        entry_o.data0 = 16'(u_pix) << cfg_i.shift_amount;
        entry_o.mask0 = 8'hff;
        entry_o.last0 = u_last;
        buf_d         = u_buf_n;
        cnt_d         = u_cnt_n;
        pc_d          = u_fire ? pc_q + 1'b1 : pc_q;
        start_d       = 1'b0;
      end
      default: begin
        has_res       = 1'b1;
        entry_o.data0 = 16'(p_buf[7:0]);
        entry_o.mask0 = p_fmask;
        entry_o.last0 = 1'b0;
        entry_o.two   = p_full2 || in_last_i;
        entry_o.data1 = p_full2 ? p_buf[15:8] : (p_buf_n[7:0] & p_tmask);
        entry_o.mask1 = p_full2 ? 8'hff : p_tmask;
        entry_o.last1 = in_last_i;
        buf_d         = p_buf_n;
        cnt_d         = p_cnt_n;
        start_d       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q   <= '0;
      cnt_q   <= '0;
      pc_q    <= '0;
      start_q <= 1'b1;
    end else if (clear_i || (accept && in_last_i)) begin
      buf_q   <= '0;
      cnt_q   <= '0;
      pc_q    <= '0;
      start_q <= 1'b1;
    end else if (accept) begin
      buf_q   <= buf_d;
      cnt_q   <= cnt_d;
      pc_q    <= pc_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/rlpu_back.sv =====
// back part: drains one queued result per unstalled cycle into the output register
// depends on rlpu_pkg (entry_t)
`timescale 1ns / 1ps
`default_nettype none

module rlpu_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire rlpu_pkg::entry_t q_head_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [15:0]           out_data_o,
  output logic [7:0]            out_mask_o,
  output logic                  out_last_o
);

  logic        valid_q, valid_d;
  logic        idx_q, idx_d;
  logic [15:0] data_q, data_d;
  logic [7:0]  mask_q, mask_d;
  logic        last_q, last_d;
  logic        load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    data_d  = data_q;
    mask_d  = mask_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = !q_empty_i;
      if (!q_empty_i) begin
        if (idx_q) begin
          data_d = 16'(q_head_i.data1);
          mask_d = q_head_i.mask1;
          last_d = q_head_i.last1;
        end else begin
          data_d = q_head_i.data0;
          mask_d = q_head_i.mask0;
          last_d = q_head_i.last0;
        end
        // entry leaves the queue with its final result
        q_pop_o = idx_q || !q_head_i.two;
        idx_d   = !q_pop_o;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    mask_q <= mask_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_mask_o  = mask_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

// ===== design/rlpu_checker.sv =====
// port-level checker for raw10_line_pack_unpack, attached by bind
// depends on rlpu_pkg and raw10_line_pack_unpack_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "raw10_line_pack_unpack_macros.svh"

module rlpu_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  input  wire logic                              cfg_ready_o,
  input  wire logic [rlpu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [rlpu_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              s_axis_tvalid_i,
  input  wire logic                              s_axis_tready_o,
  input  wire logic [15:0]                       s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,
  input  wire logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  input  wire logic [23:0]                       m_axis_tdata_o,
  input  wire logic                              m_axis_tlast_o
);

  logic [1:0] mode_q;
  logic       stall;
  logic       byte_mode;
  logic       full_mask_mode;

  // shadow of the mode register seen on the cfg channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rlpu_pkg::MODE_COPY;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i == rlpu_pkg::REG_MODE)) begin
      mode_q <= cfg_data_i[1:0];
    end
  end

  assign stall          = m_axis_tvalid_o && !m_axis_tready_i;
  assign byte_mode      = (mode_q != rlpu_pkg::MODE_UNPACK);
  assign full_mask_mode = (mode_q == rlpu_pkg::MODE_COPY) || (mode_q == rlpu_pkg::MODE_UNPACK);

  `RLPU_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, stall, m_axis_tvalid_o, "output dropped while stalled")
  `RLPU_ASSERT_NEXT(a_out_data_held, clk_i, rst_ni, stall, $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output changed while stalled")
  `RLPU_ASSERT(a_full_mask, clk_i, rst_ni, (m_axis_tvalid_o && full_mask_mode) |-> (m_axis_tdata_o[23:16] == 8'hff), "partial mask outside pack mode")
  `RLPU_ASSERT(a_byte_width, clk_i, rst_ni, (m_axis_tvalid_o && byte_mode) |-> (m_axis_tdata_o[15:8] == 8'h00), "wide data in a byte mode")

  // unused port bits kept visible to the checker for completeness
  logic unused_in;
  assign unused_in = s_axis_tvalid_i ^ s_axis_tready_o ^ (^s_axis_tdata_i) ^ s_axis_tlast_i;

endmodule

bind raw10_line_pack_unpack rlpu_checker u_rlpu_checker (.*);

`default_nettype wire

// ===== dv/raw10_line_pack_unpack_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for raw10_line_pack_unpack: copy, unpack and pack lines
// checked against an in-bench predictor, with random stalls on both streams
// depends on rlpu_pkg and raw10_line_pack_unpack
module raw10_line_pack_unpack_tb;

  localparam int unsigned MAX_PIXELS    = 4096;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned REPORT_LIMIT  = 10;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [rlpu_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd4;
  localparam logic [rlpu_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

  typedef struct packed {
    logic [15:0] data;
    logic [7:0]  mask;
    logic        line_end;
  } conv_word_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_valid_i     = 1'b0;
  logic                            cfg_ready_o;
  logic [rlpu_pkg::CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [rlpu_pkg::CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [15:0]                     s_axis_tdata_i  = '0;  // [15:0] in_data
  logic                            s_axis_tlast_i  = 1'b0; // in_line_end
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [23:0]                     m_axis_tdata_o;        // [15:0] out_data, [23:16] byte_mask
  logic                            m_axis_tlast_o;        // out_line_end

  // predictor copy of the registers and the line state
  logic [1:0]  reg_mode        = rlpu_pkg::MODE_COPY;
  logic [12:0] reg_line_pixels = 13'd1;
  logic [3:0]  reg_shift       = 4'd0;
  logic [2:0]  reg_offset      = 3'd0;
  logic [15:0] acc_bits        = '0;
  int unsigned acc_count       = 0;
  int unsigned line_pix_count  = 0;
  bit          line_fresh      = 1'b1;

  conv_word_t  expected_words[$];
  int unsigned mismatches     = 0;
  bit          tx_steady      = 1'b0;
  bit          rx_steady      = 1'b0;
  int unsigned rx_hold_cycles = 0;
  bit          rx_holding     = 1'b0;

  raw10_line_pack_unpack #(
    .MAX_LINE_PIXELS(MAX_PIXELS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_line();
    acc_bits       = '0;
    acc_count      = 0;
    line_pix_count = 0;
    line_fresh     = 1'b1;
  endfunction

  // expected results of one accepted item, appended to expected_words
  function automatic void convert_item(logic [15:0] word, logic line_end);
    conv_word_t  outs[2];
    int unsigned n;
    int unsigned limit;
    logic [2:0]  off;
    logic [9:0]  pix;
    logic [15:0] wide;
    logic [7:0]  lead_mask;
    logic [7:0]  tail_mask;
    n   = 0;
    off = reg_offset & 3'b110;
    if (reg_mode == rlpu_pkg::MODE_COPY) begin
      outs[0] = {8'h00, word[7:0], 8'hff, line_end};
      n = 1;
    end else if (reg_mode == rlpu_pkg::MODE_UNPACK) begin
      limit = (reg_line_pixels > MAX_PIXELS) ? MAX_PIXELS : reg_line_pixels;
      if (line_fresh) begin
        acc_bits   = {8'h00, word[7:0]} >> off;
        acc_count  = 8 - off;
        line_fresh = 1'b0;
      end else begin
        acc_bits  = acc_bits | ({8'h00, word[7:0]} << (acc_count & 15));
        acc_count = acc_count + 8;
      end
      if (acc_count >= 10) begin
        pix       = acc_bits[9:0];
        acc_bits  = acc_bits >> 10;
        acc_count = acc_count - 10;
        // pixels past the line limit are consumed and dropped
        if (line_pix_count < limit) begin
          line_pix_count++;
          wide    = {6'b0, pix};
          wide    = wide << reg_shift;
          outs[0] = {wide, 8'hff, (line_pix_count == limit) ? 1'b1 : line_end};
          n = 1;
        end
      end
    end else begin
      // pack, also taken for the spare mode value
      pix       = 10'(word >> reg_shift);
      lead_mask = 8'hff;
      if (line_fresh) begin
        acc_bits   = '0;
        acc_count  = off;
        lead_mask  = 8'hff << off;
        line_fresh = 1'b0;
      end
      wide      = {6'b0, pix};
      acc_bits  = acc_bits | (wide << (acc_count & 7));
      acc_count = (acc_count & 7) + 10;
      while (acc_count >= 8 && n < 2) begin
        outs[n]   = {8'h00, acc_bits[7:0], lead_mask, 1'b0};
        n++;
        lead_mask = 8'hff;
        acc_bits  = acc_bits >> 8;
        acc_count = acc_count - 8;
      end
      // partial tail byte at line end, only if room is left
      if (line_end && acc_count > 0 && n < 2) begin
        tail_mask = 8'hff >> (8 - acc_count);
        outs[n]   = {8'h00, acc_bits[7:0] & tail_mask, tail_mask, 1'b0};
        n++;
      end
      if (n > 0) outs[n-1].line_end = line_end;
    end
    for (int i = 0; i < n; i++) expected_words.push_back(outs[i]);
    if (line_end) clear_line();
  endfunction

  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_mismatch(string what, conv_word_t want, conv_word_t seen);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected data %h mask %h last %b, got data %h mask %h last %b",
               $time, what, want.data, want.mask, want.line_end,
               seen.data, seen.mask, seen.line_end);
  endfunction

  task automatic send_item(input logic [15:0] word, input logic line_end);
    int unsigned gap;
    gap = (tx_steady || $urandom_range(0, 99) < 50) ? 0 : idle_length();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= word;
    s_axis_tlast_i  <= line_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    convert_item(word, line_end);
  endtask

  // always advances past a clock edge so valid is not dropped and raised in one step
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic write_reg(input logic [rlpu_pkg::CFG_IDX_W-1:0] index,
                           input logic [rlpu_pkg::CFG_DATA_W-1:0] value);
    drain_results();
    // an unpack byte may still be in flight without a result
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (index)
      rlpu_pkg::REG_MODE: begin
        reg_mode = value[1:0];
        clear_line();
      end
      rlpu_pkg::REG_LINE_PIXELS: reg_line_pixels = value;
      rlpu_pkg::REG_SHIFT:       reg_shift = value[3:0];
      rlpu_pkg::REG_START_BIT:   reg_offset = value[2:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [1:0] mode_val, input logic [12:0] pixels,
                           input logic [3:0] shift_val, input logic [2:0] offset_val);
    write_reg(rlpu_pkg::REG_MODE, {11'b0, mode_val});
    write_reg(rlpu_pkg::REG_LINE_PIXELS, pixels);
    write_reg(rlpu_pkg::REG_SHIFT, {9'b0, shift_val});
    write_reg(rlpu_pkg::REG_START_BIT, {10'b0, offset_val});
  endtask

  task automatic test_copy_mode();
    configure(rlpu_pkg::MODE_COPY, 13'd1, 4'd0, 3'd0);
    send_item(16'h0000, 1'b0);
    send_item(16'hffff, 1'b1);
    send_item(16'h00a5, 1'b1);
  endtask

  task automatic test_unpack_mode();
    // odd offset acts as 2, third pixel hits the limit, later pixel dropped
    configure(rlpu_pkg::MODE_UNPACK, 13'd3, 4'd15, 3'd3);
    send_item(16'h00ff, 1'b0);
    send_item(16'hff00, 1'b0);
    send_item(16'h00a5, 1'b0);
    send_item(16'h005a, 1'b0);
    send_item(16'h00ff, 1'b0);
    send_item(16'h00ff, 1'b1);
    // zero line length emits nothing
    write_reg(rlpu_pkg::REG_LINE_PIXELS, 13'd0);
    send_item(16'h1234, 1'b0);
    send_item(16'hffff, 1'b1);
    // length above the cap; line end on a byte that makes no pixel
    configure(rlpu_pkg::MODE_UNPACK, 13'h1fff, 4'd0, 3'd6);
    send_item(16'h00c0, 1'b0);
    send_item(16'h00ff, 1'b0);
    send_item(16'h0081, 1'b1);
  endtask

  task automatic test_pack_mode();
    configure(rlpu_pkg::MODE_PACK, 13'd1, 4'd6, 3'd6);
    send_item(16'hffff, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h1234, 1'b1);
    configure(MODE_SPARE, 13'd1, 4'd0, 3'd0);
    send_item(16'h03ff, 1'b1);
    send_item(16'hffff, 1'b0);
    send_item(16'hfc00, 1'b1);
  endtask

  task automatic test_spare_index();
    write_reg(REG_SPARE_FIRST, 13'h1fff);
    write_reg(REG_SPARE_LAST, 13'h0aaa);
    send_item(16'h5555, 1'b0);
    send_item(16'haaaa, 1'b1);
  endtask

  task automatic test_output_stall();
    configure(rlpu_pkg::MODE_PACK, 13'd1, 4'd0, 3'd2);
    rx_hold_cycles = 300;
    wait (rx_holding);
    tx_steady = 1'b1;
    for (int k = 0; k < 40; k++) send_item(16'($urandom()), (k % 8) == 7);
    tx_steady = 1'b0;
  endtask

  task automatic test_drain_pause();
    configure(rlpu_pkg::MODE_UNPACK, 13'd8, 4'd6, 3'd0);
    repeat (3) begin
      for (int k = 0; k < 10; k++) send_item(16'($urandom()), k == 9);
      drain_results();
    end
  endtask

  task automatic test_random_lines();
    int unsigned sent;
    int unsigned pick;
    int unsigned lp;
    int unsigned len;
    int unsigned lines;
    logic [1:0]  m;
    logic [3:0]  sh;
    logic [2:0]  off;
    bit          open_end;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) m = rlpu_pkg::MODE_COPY;
      else if (pick < 55) m = rlpu_pkg::MODE_UNPACK;
      else if (pick < 90) m = rlpu_pkg::MODE_PACK;
      else m = MODE_SPARE;
      pick = $urandom_range(0, 99);
      if (pick < 80) lp = $urandom_range(1, 40);
      else if (pick < 87) lp = 0;
      else if (pick < 93) lp = MAX_PIXELS;
      else lp = $urandom_range(MAX_PIXELS + 1, 8191);
      sh  = 4'($urandom_range(0, 15));
      off = 3'($urandom_range(0, 7));
      // keeping the mode leaves any open line running across the other writes
      if (m != reg_mode || $urandom_range(0, 1) == 1)
        write_reg(rlpu_pkg::REG_MODE, {11'b0, m});
      write_reg(rlpu_pkg::REG_LINE_PIXELS, 13'(lp));
      write_reg(rlpu_pkg::REG_SHIFT, {9'b0, sh});
      write_reg(rlpu_pkg::REG_START_BIT, {10'b0, off});
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      lines = $urandom_range(2, 5);
      repeat (lines) begin
        if (m == rlpu_pkg::MODE_UNPACK && lp != 0 && lp <= 40 && $urandom_range(0, 9) < 7)
          len = (lp * 10 + (off & 3'b110) + 7) / 8;
        else if (m == rlpu_pkg::MODE_COPY)
          len = $urandom_range(1, 16);
        else
          len = $urandom_range(1, 24);
        open_end = ($urandom_range(0, 9) == 0);
        for (int k = 1; k <= len; k++)
          send_item(16'($urandom()), (k == len) && !open_end);
        sent += len;
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
    end
  endtask

  // output side: random ready, plus a long hold when asked
  initial begin : result_sink
    int unsigned span;
    wait (rst_ni);
    forever begin
      if (rx_hold_cycles != 0) begin
        span = rx_hold_cycles;
        m_axis_tready_i <= 1'b0;
        rx_holding = 1'b1;
        repeat (span) @(posedge clk_i);
        rx_hold_cycles = 0;
        rx_holding = 1'b0;
      end else if (rx_steady || $urandom_range(0, 99) < 60) begin
        m_axis_tready_i <= 1'b1;
        repeat (rx_steady ? 1 : $urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b0;
        repeat (idle_length()) @(posedge clk_i);
      end
    end
  end

  initial begin : result_check
    conv_word_t seen;
    conv_word_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        seen = {m_axis_tdata_o[15:0], m_axis_tdata_o[23:16], m_axis_tlast_o};
        if (expected_words.size() == 0) begin
          note_mismatch("unexpected result", '0, seen);
        end else begin
          want = expected_words.pop_front();
          if (seen.data !== want.data) note_mismatch("out_data", want, seen);
          if (seen.mask !== want.mask) note_mismatch("byte_mask", want, seen);
          if (seen.line_end !== want.line_end) note_mismatch("out_line_end", want, seen);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
    $display("raw10_line_pack_unpack_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_copy_mode();
    test_unpack_mode();
    test_pack_mode();
    test_spare_index();
    test_output_stall();
    test_drain_pause();
    test_random_lines();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("raw10_line_pack_unpack_tb OK");
    else
      $display("raw10_line_pack_unpack_tb NOT OK");
    $finish;
  end

endmodule
